[sv/ppc_pkg.sv]
package ppc_pkg;

  typedef struct packed {
    logic               first_in_sequence;
    logic signed [31:0] step_x;
    logic signed [31:0] step_y;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic        [15:0] out_heading;
  } out_item_t;

  // configuration register indexes
  localparam logic [1:0] CFG_INIT_X       = 2'd0;
  localparam logic [1:0] CFG_INIT_Y       = 2'd1;
  localparam logic [1:0] CFG_INIT_HEADING = 2'd2;

  localparam int CW = 40;  // CORDIC datapath width
  localparam int MW = 33;  // multiplier operand width
  localparam int AW = 66;  // accumulator width
  localparam int TABLE_LEN = 32;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 40'sd652032875;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  typedef struct packed {
    logic       load;
    logic       step;
    logic       vec;   // vectoring when set, rotation otherwise
    logic [4:0] idx;
  } cordic_ctl_t;

  function automatic logic [31:0] atan_ang(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

[sv/ppc_in_if.sv]
interface ppc_in_if import ppc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[sv/ppc_out_if.sv]
interface ppc_out_if import ppc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[sv/ppc_cordic.sv]
module ppc_cordic import ppc_pkg::*; (
  input  logic                 clk,
  input  cordic_ctl_t          ctl,
  input  logic signed [CW-1:0] load_x,
  input  logic signed [CW-1:0] load_y,
  input  logic        [31:0]   load_z,
  output logic signed [CW-1:0] x,
  output logic signed [CW-1:0] y,
  output logic        [31:0]   z
);
  logic signed [CW-1:0] xs, ys, x_next, y_next;
  logic        [31:0]   z_next, ang;
  logic                 neg;

  always_comb begin
    xs  = x >>> ctl.idx;
    ys  = y >>> ctl.idx;
    ang = atan_ang(ctl.idx);
    // vectoring drives y towards zero, rotation drives z towards zero
    neg = ctl.vec ? (y > 0) : z[31];
    if (neg) begin
      x_next = x + ys;
      y_next = y - xs;
      z_next = z + ang;
    end else begin
      x_next = x - ys;
      y_next = y + xs;
      z_next = z - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x <= load_x;
      y <= load_y;
      z <= load_z;
    end else if (ctl.step) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
    end
  end
endmodule

[sv/planar_pose_composition.sv]
// Channel  | Dir | Payload                                  | Transfer
// in_ch    | in  | first flag, step x/y, quaternion x/y/z/w | valid & ready
// out_ch   | out | x, y, heading                            | valid & ready
// cfg      | in  | cfg_we, cfg_index, cfg_data              | cfg_we
//
// A first-in-sequence item offers its result the cycle after its transfer.
// Other items go from input transfer to the earliest result transfer through
// these steps (STEPS is ROTATION_STEPS capped at 32): quaternion products
// on one shared multiplier, a load and STEPS vectoring
// steps for yaw, a load and STEPS rotation steps for cos/sin of the heading,
// more products on the same multiplier and an update of the pose.
// One item is in flight at a time; in_ch.ready is low from the input
// transfer until the cycle after the result transfer, and during reset.
// A stalled output simply holds the result.
// Synchronous reset clears the pose, the initial pose and the sequencer.
module planar_pose_composition import ppc_pkg::*; #(
  parameter int ROTATION_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  ppc_in_if.sink      in_ch,
  ppc_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int STEPS = (ROTATION_STEPS > TABLE_LEN) ? TABLE_LEN : ROTATION_STEPS;
  localparam logic [4:0] LAST_STEP = 5'(STEPS - 1);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MULQ = 9'b000000010,
    S_VLD  = 9'b000000100,
    S_VEC  = 9'b000001000,
    S_RLD  = 9'b000010000,
    S_ROT  = 9'b000100000,
    S_MULR = 9'b001000000,
    S_FIN  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state;
  in_item_t item;
  logic signed [31:0] init_x, init_y, pose_x, pose_y;
  logic        [15:0] init_heading, pose_heading, yaw16;
  logic        [2:0]  k;
  logic        [4:0]  i;
  logic signed [AW-1:0] prod, acc_a, acc_b;
  logic               yaw_zero, flip;
  out_item_t          res;

  cordic_ctl_t        cctl;
  logic signed [CW-1:0] cx, cy, lx, ly;
  logic        [31:0]   cz, lz;

  ppc_cordic u_cordic (
    .clk(clk), .ctl(cctl), .load_x(lx), .load_y(ly), .load_z(lz),
    .x(cx), .y(cy), .z(cz)
  );

  // cos/sin with the half-turn flip applied
  logic signed [CW-1:0] cos_v, sin_v;
  logic signed [MW-1:0] op_a, op_b;
  logic signed [CW-1:0] num, den;
  logic        [31:0]   head_ang;
  logic signed [AW-1:0] dx, dy;
  logic signed [36:0]   sum_x, sum_y;
  logic signed [31:0]   new_x, new_y;

  always_comb begin
    cos_v = flip ? -cx : cx;
    sin_v = flip ? -cy : cy;
    op_a = '0;
    op_b = '0;
    if (state == S_MULQ) begin
      case (k)
        3'd0: begin op_a = MW'(item.quat_w); op_b = MW'(item.quat_z); end
        3'd1: begin op_a = MW'(item.quat_x); op_b = MW'(item.quat_y); end
        3'd2: begin op_a = MW'(item.quat_w); op_b = MW'(item.quat_w); end
        3'd3: begin op_a = MW'(item.quat_x); op_b = MW'(item.quat_x); end
        3'd4: begin op_a = MW'(item.quat_y); op_b = MW'(item.quat_y); end
        3'd5: begin op_a = MW'(item.quat_z); op_b = MW'(item.quat_z); end
        default: begin op_a = '0; op_b = '0; end
      endcase
    end else begin
      case (k)
        3'd0: begin op_a = cos_v[MW-1:0]; op_b = MW'(item.step_x); end
        3'd1: begin op_a = sin_v[MW-1:0]; op_b = MW'(item.step_y); end
        3'd2: begin op_a = sin_v[MW-1:0]; op_b = MW'(item.step_x); end
        3'd3: begin op_a = cos_v[MW-1:0]; op_b = MW'(item.step_y); end
        default: begin op_a = '0; op_b = '0; end
      endcase
    end

    // yaw = atan2(num, den); num is twice acc_a
    num = CW'(acc_a) <<< 1;
    den = CW'(acc_b);
    head_ang = {pose_heading, 16'h0000};

    cctl.load = (state == S_VLD) || (state == S_RLD);
    cctl.step = (state == S_VEC) || (state == S_ROT);
    cctl.vec  = (state == S_VLD) || (state == S_VEC);
    cctl.idx  = i;
    if (state == S_VLD) begin
      lx = (den < 0) ? -den : den;
      ly = (den < 0) ? -num : num;
      lz = (den < 0) ? HALF_TURN : 32'h0;
    end else begin
      lx = CORDIC_GAIN;
      ly = '0;
      lz = ((head_ang - QUARTER_TURN) < HALF_TURN) ? head_ang - HALF_TURN : head_ang;
    end

    // round half up at bit 30, then saturate the position
    dx = (acc_a + (AW'(1) <<< 29)) >>> 30;
    dy = (acc_b + (AW'(1) <<< 29)) >>> 30;
    sum_x = 37'(pose_x) + dx[36:0];
    sum_y = 37'(pose_y) + dy[36:0];
    if (sum_x > 37'sd2147483647)       new_x = 32'sh7FFF_FFFF;
    else if (sum_x < -37'sd2147483648) new_x = 32'sh8000_0000;
    else                               new_x = sum_x[31:0];
    if (sum_y > 37'sd2147483647)       new_y = 32'sh7FFF_FFFF;
    else if (sum_y < -37'sd2147483648) new_y = 32'sh8000_0000;
    else                               new_y = sum_y[31:0];
  end

  assign in_ch.ready    = (state == S_IDLE) && !rst;
  assign out_ch.valid   = (state == S_OUT);
  assign out_ch.payload = res;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      init_x       <= '0;
      init_y       <= '0;
      init_heading <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INIT_X:       init_x       <= cfg_data;
        CFG_INIT_Y:       init_y       <= cfg_data;
        CFG_INIT_HEADING: init_heading <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // product register and accumulators; each product is accumulated in the cycle after it is formed
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    if (state == S_IDLE || state == S_ROT) begin
      acc_a <= '0;
      acc_b <= '0;
    end else if (state == S_MULQ && k != 3'd0) begin
      case (k)
        3'd1, 3'd2: acc_a <= acc_a + prod;
        3'd3, 3'd4: acc_b <= acc_b + prod;
        3'd5, 3'd6: acc_b <= acc_b - prod;
        default: ;
      endcase
    end else if (state == S_MULR && k != 3'd0) begin
      case (k)
        3'd1: acc_a <= acc_a + prod;
        3'd2: acc_a <= acc_a - prod;
        3'd3, 3'd4: acc_b <= acc_b + prod;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pose_x       <= '0;
      pose_y       <= '0;
      pose_heading <= '0;
      k            <= '0;
      i            <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            item <= in_ch.payload;
            k    <= '0;
            if (in_ch.payload.first_in_sequence) begin
              pose_x       <= init_x;
              pose_y       <= init_y;
              pose_heading <= init_heading;
              res          <= '{init_x, init_y, init_heading};
              state        <= S_OUT;
            end else begin
              state <= S_MULQ;
            end
          end
        end
        S_MULQ: begin
          k <= k + 3'd1;
          if (k == 3'd6) state <= S_VLD;
        end
        S_VLD: begin
          yaw_zero <= (num == 0) && (den == 0);
          i        <= '0;
          state    <= S_VEC;
        end
        S_VEC: begin
          i <= i + 5'd1;
          if (i == LAST_STEP) state <= S_RLD;
        end
        S_RLD: begin
          yaw16 <= yaw_zero ? 16'h0 : 16'((cz + 32'h8000) >> 16);
          flip  <= (head_ang - QUARTER_TURN) < HALF_TURN;
          i     <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          i <= i + 5'd1;
          if (i == LAST_STEP) begin
            k     <= '0;
            state <= S_MULR;
          end
        end
        S_MULR: begin
          k <= k + 3'd1;
          if (k == 3'd4) state <= S_FIN;
        end
        S_FIN: begin
          pose_x       <= new_x;
          pose_y       <= new_y;
          pose_heading <= pose_heading + yaw16;
          res          <= '{new_x, new_y, pose_heading + yaw16};
          state        <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[sv/ppc_checker.sv]
module ppc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  // hold a result until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("ready after transfer");

  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> !out_valid) else $error("result repeated");
endmodule

bind planar_pose_composition ppc_checker u_ppc_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready)
);
